>>> design/tcis_pkg.sv
`default_nettype none
package tcis_pkg;
    typedef enum logic [3:0] {
        OP_NOP = 4'd0, OP_LOAD = 4'd1, OP_ADD = 4'd2, OP_STW = 4'd3, OP_JMP = 4'd4,
        OP_JZ = 4'd5, OP_AND = 4'd6, OP_OR = 4'd7, OP_XOR = 4'd8, OP_NOT = 4'd9,
        OP_CALL = 4'd10, OP_RET = 4'd11, OP_IN = 4'd12, OP_OUT = 4'd13, OP_HALT = 4'd14,
        OP_BAD = 4'd15
    } opcode_t;

    typedef enum logic [2:0] {
        ST_RUN = 3'd0, ST_HALT = 3'd1, ST_BADOP = 3'd2, ST_PCRANGE = 3'd3,
        ST_OVER = 3'd4, ST_UNDER = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_F0, S_F1, S_F2, S_F3, S_POP0, S_POP1, S_WR0, S_WR1, S_OUT
    } state_t;

    localparam logic [15:0] IO_PORT = 16'hFF00;
    localparam logic [15:0] INPUT_RESET = 16'd65;
endpackage
`default_nettype wire

>>> design/tcis_ram.sv
`default_nettype none
module tcis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> design/tiny_cpu_instruction_step_unit.sv
`default_nettype none
// Channel   Dir  Handshake        Contents
// s_axis    in   tvalid/tready    tuser=operation, tdata={data_byte,address}
// m_axis    out  tvalid/tready    tdata={out_byte,out_valid,stack_pointer,program_counter,status}
// cfg       in   cfg_we           cfg_data=input_port_value
//
// A step accesses the single-port byte memory one byte at a time (opcode, register
// byte, two operand bytes, two stack or store bytes).
// After reset the memory is cleared one byte a cycle, and no item is taken until all of it is clear.
// A result sits in an output register; the next item is taken while it waits, and
// a second result stalls the sequencer until the first has gone.
module tiny_cpu_instruction_step_unit #(
    parameter int MEM_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // address[15:0], data_byte[23:16]
    input  wire logic        s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // status, program_counter, stack_pointer,
                                             // out_valid, out_byte, zero fill
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data
);
    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [16:0] MEMSZ = 17'(MEM_BYTES);

    tcis_pkg::state_t state_reg, state_next;
    logic [15:0] pc_reg, pc_next;
    logic [16:0] sp_reg, sp_next;
    tcis_pkg::status_t halt_reg, halt_next;
    logic [15:0] regs_reg [8];
    logic [15:0] regs_next [8];
    logic [15:0] inp_reg;
    logic [7:0] op_reg, op_next, rb_reg, rb_next, lo_reg, lo_next;
    logic [15:0] v_reg, v_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic rd_ok_reg, rd_ok_next;
    logic ov_reg, ov_next;
    logic [7:0] ob_reg, ob_next;
    logic [47:0] out_reg;
    logic outv_reg;
    logic fin;

    logic mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0] mem_wdata, mem_rdata, rbyte;

    tcis_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
    );

    assign rbyte = rd_ok_reg ? mem_rdata : 8'd0;
    assign s_axis_tready = (state_reg == tcis_pkg::S_IDLE);
    assign m_axis_tvalid = outv_reg;
    assign m_axis_tdata = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcis_pkg::S_CLEAR;
            pc_reg <= 16'd0;
            sp_reg <= MEMSZ;
            halt_reg <= tcis_pkg::ST_RUN;
            for (int i = 0; i < 8; i++)
            begin
                regs_reg[i] <= 16'd0;
            end
            inp_reg <= tcis_pkg::INPUT_RESET;
            clr_reg <= '0;
            outv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg <= pc_next;
            sp_reg <= sp_next;
            halt_reg <= halt_next;
            regs_reg <= regs_next;
            clr_reg <= clr_next;
            if (cfg_we)
            begin
                inp_reg <= cfg_data;
            end
            if (fin)
            begin
                outv_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                outv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        rb_reg <= rb_next;
        lo_reg <= lo_next;
        v_reg <= v_next;
        rd_ok_reg <= rd_ok_next;
        ov_reg <= ov_next;
        ob_reg <= ob_next;
        if (fin)
        begin
            out_reg <= {3'd0, ob_next, ov_next, sp_next, pc_next, halt_next};
        end
    end

    // True when the address lies inside memory.
    function automatic logic in_mem(input logic [15:0] a);
        in_mem = 17'(a) < MEMSZ;
    endfunction

    always_comb
    begin
        logic [15:0] x;
        logic [15:0] r;
        logic ok;
        logic [16:0] s2;
        state_next = state_reg;
        pc_next = pc_reg;
        sp_next = sp_reg;
        halt_next = halt_reg;
        regs_next = regs_reg;
        op_next = op_reg;
        rb_next = rb_reg;
        lo_next = lo_reg;
        v_next = v_reg;
        rd_ok_next = 1'b0;
        ov_next = ov_reg;
        ob_next = ob_reg;
        clr_next = clr_reg;
        mem_we = 1'b0;
        mem_addr = pc_reg[AW-1:0];
        mem_wdata = 8'd0;
        fin = 1'b0;
        x = 16'd0;
        r = regs_reg[rb_reg[2:0]];
        ok = rb_reg < 8'd8;
        s2 = sp_reg - 17'd2;
        case (state_reg)
            tcis_pkg::S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == MEM_BYTES - 1)
                begin
                    state_next = tcis_pkg::S_IDLE;
                end
            end
            tcis_pkg::S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    ov_next = 1'b0;
                    ob_next = 8'd0;
                    if (!s_axis_tuser)
                    begin
                        mem_addr = s_axis_tdata[AW-1:0];
                        mem_wdata = s_axis_tdata[23:16];
                        mem_we = in_mem(s_axis_tdata[15:0]);
                        state_next = tcis_pkg::S_OUT;
                    end
                    else if (halt_reg != tcis_pkg::ST_RUN)
                    begin
                        state_next = tcis_pkg::S_OUT;
                    end
                    else if (!in_mem(pc_reg))
                    begin
                        halt_next = tcis_pkg::ST_PCRANGE;
                        state_next = tcis_pkg::S_OUT;
                    end
                    else
                    begin
                        rd_ok_next = 1'b1;
                        pc_next = pc_reg + 16'd1;
                        state_next = tcis_pkg::S_F0;
                    end
                end
            end
            tcis_pkg::S_F0:
            begin
                op_next = rbyte;
                rd_ok_next = in_mem(pc_reg);
                case (rbyte)
                    8'(tcis_pkg::OP_NOP): state_next = tcis_pkg::S_OUT;
                    8'(tcis_pkg::OP_HALT):
                    begin
                        halt_next = tcis_pkg::ST_HALT;
                        state_next = tcis_pkg::S_OUT;
                    end
                    8'(tcis_pkg::OP_RET):
                    begin
                        if (sp_reg > MEMSZ - 17'd2)
                        begin
                            halt_next = tcis_pkg::ST_UNDER;
                            pc_next = 16'd0;
                            state_next = tcis_pkg::S_OUT;
                        end
                        else
                        begin
                            mem_addr = sp_reg[AW-1:0];
                            state_next = tcis_pkg::S_POP0;
                        end
                    end
                    8'(tcis_pkg::OP_JMP), 8'(tcis_pkg::OP_CALL):
                    begin
                        pc_next = pc_reg + 16'd1;
                        state_next = tcis_pkg::S_F2;
                    end
                    default:
                    begin
                        if (rbyte > 8'(tcis_pkg::OP_HALT))
                        begin
                            halt_next = tcis_pkg::ST_BADOP;
                            state_next = tcis_pkg::S_OUT;
                        end
                        else
                        begin
                            pc_next = pc_reg + 16'd1;
                            state_next = tcis_pkg::S_F1;
                        end
                    end
                endcase
            end
            tcis_pkg::S_F1:
            begin
                rb_next = rbyte;
                if (op_reg == 8'(tcis_pkg::OP_NOT))
                begin
                    if (rbyte < 8'd8)
                    begin
                        regs_next[rbyte[2:0]] = ~regs_reg[rbyte[2:0]];
                    end
                    state_next = tcis_pkg::S_OUT;
                end
                else
                begin
                    rd_ok_next = in_mem(pc_reg);
                    pc_next = pc_reg + 16'd1;
                    state_next = tcis_pkg::S_F2;
                end
            end
            tcis_pkg::S_F2:
            begin
                lo_next = rbyte;
                rd_ok_next = in_mem(pc_reg);
                pc_next = pc_reg + 16'd1;
                state_next = tcis_pkg::S_F3;
            end
            tcis_pkg::S_F3:
            begin
                v_next = {rbyte, lo_reg};
                state_next = tcis_pkg::S_OUT;
                case (op_reg)
                    8'(tcis_pkg::OP_LOAD), 8'(tcis_pkg::OP_ADD), 8'(tcis_pkg::OP_AND),
                    8'(tcis_pkg::OP_OR), 8'(tcis_pkg::OP_XOR):
                    begin
                        case (op_reg)
                            8'(tcis_pkg::OP_LOAD): x = v_next;
                            8'(tcis_pkg::OP_ADD): x = r + v_next;
                            8'(tcis_pkg::OP_AND): x = r & v_next;
                            8'(tcis_pkg::OP_OR): x = r | v_next;
                            default: x = r ^ v_next;
                        endcase
                        if (ok)
                        begin
                            regs_next[rb_reg[2:0]] = x;
                        end
                    end
                    8'(tcis_pkg::OP_STW):
                    begin
                        if (ok && (17'(v_next) + 17'd1 < MEMSZ))
                        begin
                            mem_we = 1'b1;
                            mem_addr = v_next[AW-1:0];
                            mem_wdata = r[7:0];
                            state_next = tcis_pkg::S_WR1;
                        end
                    end
                    8'(tcis_pkg::OP_JMP):
                    begin
                        if (in_mem(v_next))
                        begin
                            pc_next = v_next;
                        end
                    end
                    8'(tcis_pkg::OP_JZ):
                    begin
                        if (ok && r == 16'd0 && in_mem(v_next))
                        begin
                            pc_next = v_next;
                        end
                    end
                    8'(tcis_pkg::OP_CALL):
                    begin
                        pc_next = v_next;
                        if (sp_reg < 17'd2)
                        begin
                            halt_next = tcis_pkg::ST_OVER;
                        end
                        else
                        begin
                            sp_next = s2;
                            mem_we = 1'b1;
                            mem_addr = s2[AW-1:0];
                            mem_wdata = pc_reg[7:0];
                            lo_next = pc_reg[15:8];
                            state_next = tcis_pkg::S_WR0;
                        end
                    end
                    8'(tcis_pkg::OP_IN):
                    begin
                        if (ok && v_next == tcis_pkg::IO_PORT)
                        begin
                            regs_next[rb_reg[2:0]] = inp_reg;
                        end
                    end
                    default:
                    begin
                        if (ok && v_next == tcis_pkg::IO_PORT)
                        begin
                            ov_next = 1'b1;
                            ob_next = r[7:0];
                        end
                    end
                endcase
            end
            tcis_pkg::S_WR0:
            begin
                mem_we = 1'b1;
                mem_addr = AW'(sp_reg + 17'd1);
                mem_wdata = lo_reg;
                state_next = tcis_pkg::S_OUT;
            end
            tcis_pkg::S_WR1:
            begin
                mem_we = 1'b1;
                mem_addr = AW'(17'(v_reg) + 17'd1);
                mem_wdata = r[15:8];
                state_next = tcis_pkg::S_OUT;
            end
            tcis_pkg::S_POP0:
            begin
                lo_next = mem_rdata;
                mem_addr = AW'(sp_reg + 17'd1);
                state_next = tcis_pkg::S_POP1;
            end
            tcis_pkg::S_POP1:
            begin
                pc_next = {mem_rdata, lo_reg};
                sp_next = sp_reg + 17'd2;
                state_next = tcis_pkg::S_OUT;
            end
            tcis_pkg::S_OUT:
            begin
                if (!outv_reg || m_axis_tready)
                begin
                    fin = 1'b1;
                    state_next = tcis_pkg::S_IDLE;
                end
            end
            default: state_next = tcis_pkg::S_IDLE;
        endcase
    end

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= MEMSZ) else $error("stack pointer beyond memory");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !fin) else $error("result overwritten");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(halt_reg) != tcis_pkg::ST_RUN) |-> (halt_reg == $past(halt_reg)))
        else $error("halt reason changed");
endmodule
`default_nettype wire
